### design/ahrc_pkg.sv
// ----------------------------------------------------------------------------
// ahrc_pkg
// shared types, constants and hex helpers for the ascii hex request checker
// ----------------------------------------------------------------------------
package ahrc_pkg;

	localparam int unsigned FRAME_BYTES = 20;
	localparam int unsigned POS_W       = 5;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [7:0]       SOI_BYTE = 8'h7E;
	localparam logic [7:0]       EOI_BYTE = 8'h0D;
	localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAMILY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANALOG  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM   = 3'd5;

	typedef enum logic [2:0] {
		VERDICT_ANALOG  = 3'd0,
		VERDICT_ALARM   = 3'd1,
		VERDICT_OTHER   = 3'd2,
		VERDICT_LENGTH  = 3'd3,
		VERDICT_FRAMING = 3'd4,
		VERDICT_HEADER  = 3'd5,
		VERDICT_CHECK   = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  address;
		logic [7:0]  family;
		logic [15:0] length_word;
		logic [7:0]  analog_code;
		logic [7:0]  alarm_code;
	} cfg_t;

	// upper-case ascii hex digit of one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib <= 4'd9) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h37 + {4'd0, nib};
		end
		return r;
	endfunction

	// two hex characters of a byte, high nibble in the upper byte
	function automatic logic [15:0] code_chars(input logic [7:0] code);
		return {hex_char(code[7:4]), hex_char(code[3:0])};
	endfunction

endpackage

### design/ahrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ahrc_cfg_regs
// configuration register file, write only, reset to the default frame header
// ----------------------------------------------------------------------------
module ahrc_cfg_regs
	import ahrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version     <= 8'h25;
			cfg_q.address     <= 8'h02;
			cfg_q.family      <= 8'h46;
			cfg_q.length_word <= 16'hE002;
			cfg_q.analog_code <= 8'h42;
			cfg_q.alarm_code  <= 8'h44;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERSION: cfg_q.version     <= cfg_wdata[7:0];
				REG_ADDRESS: cfg_q.address     <= cfg_wdata[7:0];
				REG_FAMILY:  cfg_q.family      <= cfg_wdata[7:0];
				REG_LENGTH:  cfg_q.length_word <= cfg_wdata;
				REG_ANALOG:  cfg_q.analog_code <= cfg_wdata[7:0];
				REG_ALARM:   cfg_q.alarm_code  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/ahrc_frame_check.sv
// ----------------------------------------------------------------------------
// ahrc_frame_check
// per-frame state: position, byte sum, sticky error marks, command characters
// ----------------------------------------------------------------------------
module ahrc_frame_check
	import ahrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	input  cfg_t       cfg,
	output verdict_t   verdict
);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic             start_bad_q;
	logic             header_bad_q;
	logic             check_bad_q;
	logic [15:0]      cmd_q;

	logic [15:0] chk;
	logic [7:0]  hdr_ref;
	logic [3:0]  want_nib;
	logic        want_hdr;
	logic        want_chk;
	logic        mismatch;
	logic        in_sum;

	assign chk = 16'd0 - sum_q;

	// expected nibble for the current position
	always_comb begin
		hdr_ref  = cfg.family;
		want_nib = 4'd0;
		want_hdr = 1'b0;
		want_chk = 1'b0;
		if (pos_q <= 5'd2) begin
			hdr_ref = cfg.version;
		end else if (pos_q <= 5'd4) begin
			hdr_ref = cfg.address;
		end
		case (pos_q)
			5'd1, 5'd3, 5'd5: begin
				want_nib = hdr_ref[7:4];
				want_hdr = 1'b1;
			end
			5'd2, 5'd4, 5'd6: begin
				want_nib = hdr_ref[3:0];
				want_hdr = 1'b1;
			end
			5'd9:  begin want_nib = cfg.length_word[15:12]; want_hdr = 1'b1; end
			5'd10: begin want_nib = cfg.length_word[11:8];  want_hdr = 1'b1; end
			5'd11: begin want_nib = cfg.length_word[7:4];   want_hdr = 1'b1; end
			5'd12: begin want_nib = cfg.length_word[3:0];   want_hdr = 1'b1; end
			5'd15: begin want_nib = chk[15:12]; want_chk = 1'b1; end
			5'd16: begin want_nib = chk[11:8];  want_chk = 1'b1; end
			5'd17: begin want_nib = chk[7:4];   want_chk = 1'b1; end
			5'd18: begin want_nib = chk[3:0];   want_chk = 1'b1; end
			default: begin
			end
		endcase
	end

	assign mismatch = (rx_byte != hex_char(want_nib));
	assign in_sum   = (pos_q >= 5'd1) && (pos_q <= 5'd14);

	// verdict in priority order
	always_comb begin
		if (pos_q != POS_LAST) begin
			verdict = VERDICT_LENGTH;
		end else if (start_bad_q || (rx_byte != EOI_BYTE)) begin
			verdict = VERDICT_FRAMING;
		end else if (header_bad_q) begin
			verdict = VERDICT_HEADER;
		end else if (check_bad_q) begin
			verdict = VERDICT_CHECK;
		end else if (cmd_q == code_chars(cfg.alarm_code)) begin
			verdict = VERDICT_ALARM;
		end else if (cmd_q == code_chars(cfg.analog_code)) begin
			verdict = VERDICT_ANALOG;
		end else begin
			verdict = VERDICT_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum_q        <= '0;
			start_bad_q  <= 1'b0;
			header_bad_q <= 1'b0;
			check_bad_q  <= 1'b0;
			cmd_q        <= '0;
		end else if (step) begin
			if (frame_end) begin
				pos_q        <= '0;
				sum_q        <= '0;
				start_bad_q  <= 1'b0;
				header_bad_q <= 1'b0;
				check_bad_q  <= 1'b0;
				cmd_q        <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 5'd1;
				end
				if (in_sum) begin
					sum_q <= sum_q + {8'd0, rx_byte};
				end
				if ((pos_q == 5'd0) && (rx_byte != SOI_BYTE)) begin
					start_bad_q <= 1'b1;
				end
				if (want_hdr && mismatch) begin
					header_bad_q <= 1'b1;
				end
				if (want_chk && mismatch) begin
					check_bad_q <= 1'b1;
				end
				if (pos_q == 5'd7) begin
					cmd_q[15:8] <= rx_byte;
				end
				if (pos_q == 5'd8) begin
					cmd_q[7:0] <= rx_byte;
				end
			end
		end
	end

endmodule

### design/ascii_hex_request_checker_core.sv
// ----------------------------------------------------------------------------
// ascii_hex_request_checker_core
// checks received ascii hex request frames and gives one verdict per frame
// ----------------------------------------------------------------------------
// usage
//   rx channel (rx_valid, rx_stall, rx_byte, frame_end): one frame byte per
//   transaction, frame_end high on the last byte of the frame
//   res channel (res_valid, res_stall, verdict): one transaction per frame,
//   given only for the byte that carries frame_end
//   cfg port (cfg_we, cfg_index, cfg_wdata): write only, used while idle
// throughput and path
//   one byte per cycle while rx_stall is low; a byte is registered in the
//   input register, and when a frame end moves on from there its verdict
//   is loaded into the result register, which drives the result port
// stalling
//   a waiting verdict is held in the result register while bytes that give
//   no verdict still flow; a second frame end waits in the input register
//   and rx_stall rises until the result is taken
// reset
//   frame state, valids and the config registers (to the default header)
//   clear asynchronously on arst_n low
// ----------------------------------------------------------------------------
module ascii_hex_request_checker_core
	import ahrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// receive channel
	input  logic                  rx_valid,
	output logic                  rx_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_end,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [2:0]            verdict,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       frame_end_s1;
	logic       move_s1;
	verdict_t   verdict_s1;
	logic       res_valid_q;
	logic [2:0] verdict_q;

	ahrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// the input byte moves on unless it carries a verdict and the
	// result register is still full and stalled
	assign move_s1  = valid_s1 && (!frame_end_s1 || !res_valid_q || !res_stall);
	assign rx_stall = valid_s1 && !move_s1;

	ahrc_frame_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (move_s1),
		.rx_byte   (rx_byte_s1),
		.frame_end (frame_end_s1),
		.cfg       (cfg),
		.verdict   (verdict_s1)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_byte_s1   <= rx_byte;
			frame_end_s1 <= frame_end;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move_s1 && frame_end_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && frame_end_s1) begin
			verdict_q <= 3'(verdict_s1);
		end
	end

	assign res_valid = res_valid_q;
	assign verdict   = verdict_q;

endmodule

### bench/ahrc_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahrc_verdict_checker
// follows the rx, result and register ports, works out the verdict each frame
// should get and compares it with the verdict the core gives
// ----------------------------------------------------------------------------
module ahrc_verdict_checker
	import ahrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	input  logic                  rx_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_end,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic [2:0]            verdict,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    waiting,
	output int                    checked,
	output logic [6:0]            kinds_seen
);

	localparam cfg_t CFG_AT_RESET = {8'h25, 8'h02, 8'h46, 16'hE002, 8'h42, 8'h44};

	cfg_t             cfg;
	logic [POS_W-1:0] pos;
	logic [15:0]      byte_sum;
	logic             soi_wrong;
	logic             header_wrong;
	logic             sum_wrong;
	logic [15:0]      cmd_chars;
	verdict_t         verdicts_due[$];
	verdict_t         want;
	int               n_err = 0;
	int               n_checked = 0;
	logic [6:0]       seen = '0;

	function automatic logic [7:0] ascii_nib(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + 8'(n);
		end else begin
			c = 8'h41 + 8'(n) - 8'd10;
		end
		return c;
	endfunction

	function automatic logic [15:0] chars_of(input logic [7:0] code);
		return {ascii_nib(code[7:4]), ascii_nib(code[3:0])};
	endfunction

	task automatic clear_frame();
		pos          = '0;
		byte_sum     = '0;
		soi_wrong    = 1'b0;
		header_wrong = 1'b0;
		sum_wrong    = 1'b0;
		cmd_chars    = '0;
	endtask

	// one accepted byte; a frame end queues the verdict the frame deserves
	task automatic take_byte(input logic [7:0] b, input logic last);
		logic [15:0] chk;
		logic [15:0] word;
		logic [7:0]  field;
		verdict_t    v;
		chk = 16'h0000 - byte_sum;
		if (pos == 5'd0) begin
			if (b != SOI_BYTE) soi_wrong = 1'b1;
		end else if (pos <= 5'd6) begin
			field = (pos <= 5'd2) ? cfg.version : (pos <= 5'd4) ? cfg.address : cfg.family;
			if (b != ascii_nib(pos[0] ? field[7:4] : field[3:0])) header_wrong = 1'b1;
		end else if (pos == 5'd7) begin
			cmd_chars[15:8] = b;
		end else if (pos == 5'd8) begin
			cmd_chars[7:0] = b;
		end else if (pos <= 5'd12) begin
			word = cfg.length_word >> (4 * (12 - int'(pos)));
			if (b != ascii_nib(word[3:0])) header_wrong = 1'b1;
		end else if (pos >= 5'd15 && pos <= 5'd18) begin
			word = chk >> (4 * (18 - int'(pos)));
			if (b != ascii_nib(word[3:0])) sum_wrong = 1'b1;
		end
		if (pos >= 5'd1 && pos <= 5'd14) byte_sum = byte_sum + 16'(b);
		if (!last) begin
			if (pos != POS_MAX) pos = pos + 5'd1;
		end else begin
			if (pos != POS_LAST) v = VERDICT_LENGTH;
			else if (soi_wrong || b != EOI_BYTE) v = VERDICT_FRAMING;
			else if (header_wrong) v = VERDICT_HEADER;
			else if (sum_wrong) v = VERDICT_CHECK;
			else if (cmd_chars == chars_of(cfg.alarm_code)) v = VERDICT_ALARM;
			else if (cmd_chars == chars_of(cfg.analog_code)) v = VERDICT_ANALOG;
			else v = VERDICT_OTHER;
			verdicts_due.push_back(v);
			clear_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = CFG_AT_RESET;
			clear_frame();
			verdicts_due.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (verdicts_due.size() == 0) begin
					n_err++;
					$display("%0t: verdict with none outstanding, expected none actual %0d",
						$time, verdict);
				end else begin
					want = verdicts_due.pop_front();
					n_checked++;
					seen[want] = 1'b1;
					if (verdict !== want) begin
						n_err++;
						$display("%0t: verdict mismatch, expected %0d (%s) actual %0d",
							$time, want, want.name(), verdict);
					end
				end
			end
			if (rx_valid && !rx_stall) take_byte(rx_byte, frame_end);
			if (cfg_we) begin
				case (cfg_index)
					REG_VERSION: cfg.version     = cfg_wdata[7:0];
					REG_ADDRESS: cfg.address     = cfg_wdata[7:0];
					REG_FAMILY:  cfg.family      = cfg_wdata[7:0];
					REG_LENGTH:  cfg.length_word = cfg_wdata;
					REG_ANALOG:  cfg.analog_code = cfg_wdata[7:0];
					REG_ALARM:   cfg.alarm_code  = cfg_wdata[7:0];
					default: ;
				endcase
			end
		end
		errors     <= n_err;
		waiting    <= verdicts_due.size();
		checked    <= n_checked;
		kinds_seen <= seen;
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// frame level test of the ascii hex request checker: directed frames for each
// verdict, then random frames under several register settings, with random
// idling on both channels and one long hold-off on the result side
// ----------------------------------------------------------------------------
module tb;
	import ahrc_pkg::*;

	// ways of spoiling an otherwise good frame
	typedef enum int {
		FLAW_NONE,
		FLAW_SOI,
		FLAW_EOI,
		FLAW_HEADER,
		FLAW_LOWER,
		FLAW_CHECK,
		FLAW_SHORT,
		FLAW_LONG,
		FLAW_HUGE
	} flaw_t;

	// indexes the core has no register behind
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int HOLD_OFF_CYCLES = 150;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  rx_valid = 1'b0;
	logic                  rx_stall;
	logic [7:0]            rx_byte = '0;
	logic                  frame_end = 1'b0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [2:0]            verdict;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int         errors;
	int         waiting;
	int         checked;
	logic [6:0] kinds_seen;

	// calm: no idling on either side; hold-off handshake with the receiver process
	bit         calm = 1'b0;
	bit         hold_off_req = 1'b0;
	bit         hold_off_done = 1'b0;
	int         bytes_sent = 0;
	int         frames_sent = 0;
	// register values the core holds now, used to build well-formed frames
	cfg_t       cur = {8'h25, 8'h02, 8'h46, 16'hE002, 8'h42, 8'h44};
	logic [7:0] frame_buf[$];

	ascii_hex_request_checker_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.verdict   (verdict),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ahrc_verdict_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.frame_end  (frame_end),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.verdict    (verdict),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.errors     (errors),
		.waiting    (waiting),
		.checked    (checked),
		.kinds_seen (kinds_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case a transaction never completes
	initial begin
		#1_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// result side: random stalls, plus one long hold-off that it times itself
	initial begin
		forever begin
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				res_stall <= !calm && ($urandom_range(99) < 11);
				@(posedge clk);
			end
		end
	end

	function automatic logic [7:0] digit_of(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
	endfunction

	// upper-case hex characters of a word, most significant nibble first
	task automatic push_digits(input logic [15:0] w, input int count);
		int k;
		for (k = count - 1; k >= 0; k--) frame_buf.push_back(digit_of(w[4*k +: 4]));
	endtask

	// one register write; the enable stays up when writes follow back to back
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// all six registers, junk in the unused upper bits, then a write to a spare index
	task automatic load_regs(input cfg_t c);
		reg_write(REG_VERSION, {8'($urandom), c.version});
		reg_write(REG_ADDRESS, {8'($urandom), c.address});
		reg_write(REG_FAMILY, {8'($urandom), c.family});
		reg_write(REG_LENGTH, c.length_word);
		reg_write(REG_ANALOG, {8'($urandom), c.analog_code});
		reg_write(REG_ALARM, {8'($urandom), c.alarm_code});
		reg_write(($urandom_range(1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
		cfg_we <= 1'b0;
		cur = c;
	endtask

	// one byte transaction, with a random gap in front unless calm
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(99) < 11) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid  <= 1'b1;
		rx_byte   <= b;
		frame_end <= last;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	// well-formed request for the current registers, then spoilt as asked
	task automatic compose_frame(input logic [7:0] code, input bit lower_cmd, input flaw_t flaw);
		logic [15:0] acc;
		logic [7:0]  b;
		int          k;
		int          n;
		int          letters[$];
		frame_buf.delete();
		frame_buf.push_back(SOI_BYTE);
		push_digits({8'h00, cur.version}, 2);
		push_digits({8'h00, cur.address}, 2);
		push_digits({8'h00, cur.family}, 2);
		push_digits({8'h00, code}, 2);
		push_digits(cur.length_word, 4);
		// two payload bytes, summed but never compared
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'($urandom));
		if (lower_cmd) begin
			k = $urandom_range(8, 7);
			frame_buf[k] = frame_buf[k] | 8'h20;
		end
		// header faults go in before the checksum so that the checksum itself stays right
		if (flaw == FLAW_LOWER) begin
			for (k = 1; k <= 12; k++) begin
				if (k != 7 && k != 8 && frame_buf[k] >= 8'h41 && frame_buf[k] <= 8'h46)
					letters.push_back(k);
			end
			if (letters.size() != 0) begin
				k = letters[$urandom_range(letters.size() - 1)];
				frame_buf[k] = frame_buf[k] | 8'h20;
			end else begin
				flaw = FLAW_HEADER;
			end
		end
		if (flaw == FLAW_HEADER) begin
			k = $urandom_range(10, 1);
			if (k > 6) k += 2;
			frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(7));
		end
		acc = '0;
		for (k = 1; k <= 14; k++) acc = acc + 16'(frame_buf[k]);
		push_digits(16'h0000 - acc, 4);
		frame_buf.push_back(EOI_BYTE);
		case (flaw)
			FLAW_SOI: begin
				do b = 8'($urandom); while (b == SOI_BYTE);
				frame_buf[0] = b;
			end
			FLAW_EOI: begin
				do b = 8'($urandom); while (b == EOI_BYTE);
				frame_buf[19] = b;
			end
			FLAW_CHECK: begin
				k = $urandom_range(18, 15);
				if (frame_buf[k] >= 8'h41 && frame_buf[k] <= 8'h46 && $urandom_range(1) != 0)
					frame_buf[k] = frame_buf[k] | 8'h20;
				else
					frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(7));
			end
			FLAW_SHORT: begin
				n = $urandom_range(19, 1);
				while (frame_buf.size() > n) void'(frame_buf.pop_back());
				if ($urandom_range(1) != 0) frame_buf[n - 1] = EOI_BYTE;
			end
			FLAW_LONG, FLAW_HUGE: begin
				// past 31 bytes the position counter sits at its ceiling
				n = (flaw == FLAW_LONG) ? $urandom_range(31, 21) : $urandom_range(44, 32);
				void'(frame_buf.pop_back());
				while (frame_buf.size() < n - 1) frame_buf.push_back(8'($urandom));
				frame_buf.push_back(EOI_BYTE);
			end
			default: ;
		endcase
	endtask

	task automatic compose_noise(input int n);
		frame_buf.delete();
		repeat (n) frame_buf.push_back(8'($urandom));
		if ($urandom_range(2) == 0) frame_buf[0] = SOI_BYTE;
	endtask

	// mostly requests with random content, half of them with one fault, some noise
	task automatic random_frame();
		int         r;
		logic [7:0] code;
		flaw_t      flaw;
		r = $urandom_range(99);
		if (r < 20) begin
			compose_noise(($urandom_range(9) == 0) ? $urandom_range(40, 21) : $urandom_range(20, 1));
		end else begin
			r = $urandom_range(99);
			code = (r < 40) ? cur.analog_code : (r < 75) ? cur.alarm_code : 8'($urandom);
			if ($urandom_range(1) != 0) flaw = FLAW_NONE;
			else flaw = flaw_t'($urandom_range(int'(FLAW_HUGE), int'(FLAW_SOI)));
			compose_frame(code, $urandom_range(9) == 0, flaw);
		end
		send_frame();
	endtask

	task automatic run_phase();
		int first;
		int f;
		first = bytes_sent;
		f = 0;
		while (bytes_sent - first < 70 || f < 4) begin
			random_frame();
			f++;
		end
	endtask

	// drop valid, wait for every verdict, then give the pipeline time to drain
	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cfg_t c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames against the reset register values
		compose_frame(cur.analog_code, 1'b0, FLAW_NONE);
		send_frame();
		compose_frame(cur.alarm_code, 1'b0, FLAW_NONE);
		send_frame();
		compose_frame(8'h4F, 1'b0, FLAW_NONE);
		send_frame();
		compose_frame(cur.analog_code, 1'b0, FLAW_SOI);
		send_frame();
		compose_frame(cur.analog_code, 1'b0, FLAW_EOI);
		send_frame();
		compose_frame(cur.alarm_code, 1'b0, FLAW_HEADER);
		send_frame();
		// the reset length word has a letter, so a lower-case header character is on hand
		compose_frame(cur.analog_code, 1'b0, FLAW_LOWER);
		send_frame();
		compose_frame(cur.alarm_code, 1'b0, FLAW_CHECK);
		send_frame();
		compose_frame(cur.analog_code, 1'b1, FLAW_NONE);
		send_frame();
		compose_frame(cur.analog_code, 1'b0, FLAW_SHORT);
		send_frame();
		compose_frame(cur.analog_code, 1'b0, FLAW_LONG);
		send_frame();
		compose_frame(cur.analog_code, 1'b0, FLAW_HUGE);
		send_frame();
		frame_buf = '{8'hFF};
		send_frame();
		frame_buf = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
		send_frame();
		settle();

		// random registers
		c = {8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)};
		load_regs(c);
		run_phase();
		settle();

		// all zeros: both command codes equal, and a long stretch with no idling
		calm = 1'b1;
		load_regs('0);
		compose_frame(8'h00, 1'b0, FLAW_NONE);
		send_frame();
		run_phase();
		settle();
		calm = 1'b0;

		// all ones
		load_regs('1);
		compose_frame(8'hFF, 1'b0, FLAW_NONE);
		send_frame();
		run_phase();
		settle();

		// random again, often with equal codes; the result side holds off meanwhile
		c = {8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)};
		if ($urandom_range(1) != 0) c.alarm_code = c.analog_code;
		load_regs(c);
		hold_off_req = 1'b1;
		run_phase();
		settle();

		$display("tb: %0d bytes in %0d frames under five register settings, %0d verdicts checked",
			bytes_sent, frames_sent, checked);
		$display("tb: verdict kinds seen %b (analog in bit 0), long result hold-off %s",
			kinds_seen, hold_off_done ? "done" : "missed");
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
design/ahrc_pkg.sv
design/ahrc_cfg_regs.sv
design/ahrc_frame_check.sv
design/ascii_hex_request_checker_core.sv
bench/ahrc_verdict_checker.sv
bench/tb.sv
